### design/b64d_pkg.sv
// Package: shared types, character codes and the symbol classifier for the Base64 decoder.
`default_nettype none
package b64d_pkg;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	localparam logic [5:0] BAD_VALUE = 6'd63;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

	// Classified symbol as it travels from the front end to the back end
	typedef struct packed {
		logic [5:0] value;
		logic       bad;
		logic       is_pad;
		logic       is_nul;
		logic       is_cr;
		logic       is_lf;
	} sym_class_t;

	typedef struct packed {
		logic               empty;
		logic               full;
		logic [Q_LVL_W-1:0] level;
	} queue_status_t;

	typedef enum logic [5:0] {
		PH_START = 6'b000001,
		PH_ONE   = 6'b000010,
		PH_TWO   = 6'b000100,
		PH_THREE = 6'b001000,
		PH_CR    = 6'b010000,
		PH_LF    = 6'b100000
	} phase_t;

	function automatic sym_class_t classify(input logic [7:0] c);
		sym_class_t r;
		r.value  = BAD_VALUE;
		r.bad    = 1'b1;
		r.is_pad = (c == CHAR_PAD);
		r.is_nul = (c == CHAR_NUL);
		r.is_cr  = (c == CHAR_CR);
		r.is_lf  = (c == CHAR_LF);
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.value = 6'(c - 8'h41);
			r.bad   = 1'b0;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.value = 6'(c - 8'h47);
			r.bad   = 1'b0;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c + 8'h04);
			r.bad   = 1'b0;
		end else if (c == CHAR_PLUS) begin
			r.value = 6'd62;
			r.bad   = 1'b0;
		end else if (c == CHAR_SLASH) begin
			r.value = 6'd63;
			r.bad   = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/b64d_front.sv
// Front end: accepts input words and classifies each character for the queue.
`default_nettype none
module b64d_front (
	input  wire logic                  symbol_valid,
	output logic                       symbol_ready,
	input  wire logic [7:0]            symbol,
	input  wire b64d_pkg::queue_status_t q_status,
	output logic                       push,
	output b64d_pkg::sym_class_t       push_data
);

	assign symbol_ready = !q_status.full;
	assign push         = symbol_valid && !q_status.full;
	assign push_data    = b64d_pkg::classify(symbol);

endmodule
`default_nettype wire

### design/b64d_queue.sv
// Short register queue between the classifier and the decode back end.
`default_nettype none
module b64d_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire b64d_pkg::sym_class_t   push_data,
	input  wire logic                   pop,
	output b64d_pkg::sym_class_t        pop_data,
	output b64d_pkg::queue_status_t     status
);

	b64d_pkg::sym_class_t                  entry_q [b64d_pkg::Q_DEPTH];
	logic [b64d_pkg::Q_PTR_W-1:0]          wr_ptr_q;
	logic [b64d_pkg::Q_PTR_W-1:0]          rd_ptr_q;
	logic [b64d_pkg::Q_LVL_W-1:0]          level_q;

	assign status.empty = (level_q == '0);
	assign status.full  = (level_q == b64d_pkg::Q_LVL_W'(b64d_pkg::Q_DEPTH));
	assign status.level = level_q;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				level_q <= level_q + 1'b1;
			else if (pop && !push)
				level_q <= level_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### design/b64d_back.sv
// Back end: group state machine, byte assembly, count and output register.
`default_nettype none
module b64d_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire b64d_pkg::queue_status_t q_status,
	input  wire b64d_pkg::sym_class_t q_data,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [7:0]                data_byte,
	output logic                      end_of_message,
	output logic                      bad_symbol_seen,
	output logic [15:0]               byte_count
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	b64d_pkg::phase_t        phase_q, phase_d;
	logic [5:0]              prev_q, prev_d;
	logic                    pad_q, pad_d;
	logic                    err_q, err_d;
	logic [COUNT_WIDTH-1:0]  count_q, count_d;

	logic                    emit;
	logic                    eom;
	logic [7:0]              byte_d;
	logic                    use_lookup;
	logic                    advance;
	logic [31:0]             count_ext;

	logic                    result_valid_q;
	logic [7:0]              data_byte_q;
	logic                    eom_q;
	logic                    bad_q;
	logic [COUNT_WIDTH-1:0]  count_out_q;

	assign advance = !result_valid_q || result_ready;
	assign pop     = !q_status.empty && advance;

	always_comb begin
		phase_d    = phase_q;
		prev_d     = prev_q;
		pad_d      = pad_q;
		count_d    = count_q;
		emit       = 1'b0;
		eom        = 1'b0;
		byte_d     = '0;
		use_lookup = 1'b0;
		unique case (phase_q)
			b64d_pkg::PH_ONE: begin
				use_lookup = 1'b1;
				emit       = 1'b1;
				byte_d     = {prev_q, q_data.value[5:4]};
				prev_d     = q_data.value;
				phase_d    = b64d_pkg::PH_TWO;
			end
			b64d_pkg::PH_TWO: begin
				if (q_data.is_pad) begin
					pad_d = 1'b1;
				end else begin
					use_lookup = 1'b1;
					emit       = 1'b1;
					byte_d     = {prev_q[3:0], q_data.value[5:2]};
					prev_d     = q_data.value;
				end
				phase_d = b64d_pkg::PH_THREE;
			end
			b64d_pkg::PH_THREE: begin
				// pad in third slot swallows the fourth symbol unchecked
				if (!pad_q && !q_data.is_pad) begin
					use_lookup = 1'b1;
					emit       = 1'b1;
					byte_d     = {prev_q[1:0], q_data.value};
					prev_d     = q_data.value;
				end
				pad_d   = 1'b0;
				phase_d = b64d_pkg::PH_CR;
			end
			default: begin
				if (q_data.is_nul) begin
					eom = 1'b1;
				end else if (phase_q == b64d_pkg::PH_CR && q_data.is_cr) begin
					phase_d = b64d_pkg::PH_LF;
				end else if (phase_q == b64d_pkg::PH_LF && q_data.is_lf) begin
					phase_d = b64d_pkg::PH_START;
				end else begin
					use_lookup = 1'b1;
					prev_d     = q_data.value;
					pad_d      = 1'b0;
					phase_d    = b64d_pkg::PH_ONE;
				end
			end
		endcase
		err_d = err_q | (use_lookup & q_data.bad);
		if (emit && count_q != COUNT_MAX)
			count_d = count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= b64d_pkg::PH_START;
			prev_q         <= '0;
			pad_q          <= 1'b0;
			err_q          <= 1'b0;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance)
				result_valid_q <= pop && (emit || eom);
			if (pop) begin
				if (eom) begin
					phase_q <= b64d_pkg::PH_START;
					prev_q  <= '0;
					pad_q   <= 1'b0;
					err_q   <= 1'b0;
					count_q <= '0;
				end else begin
					phase_q <= phase_d;
					prev_q  <= prev_d;
					pad_q   <= pad_d;
					err_q   <= err_d;
					count_q <= count_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (emit || eom)) begin
			data_byte_q <= byte_d;
			eom_q       <= eom;
			bad_q       <= err_d;
			count_out_q <= count_d;
		end
	end

	assign count_ext       = 32'(count_out_q);
	assign result_valid    = result_valid_q;
	assign data_byte       = data_byte_q;
	assign end_of_message  = eom_q;
	assign bad_symbol_seen = bad_q;
	assign byte_count      = count_ext[15:0];

endmodule
`default_nettype wire

### design/base64_decoder_crlf_skip.sv
// Top level: Base64 decoder with CR/LF skip between groups.
// A result passes through the queue entry and then the output register.
// Throughput: one symbol word per cycle; the front end stalls only when the
//   four-entry queue is full, the back end only when the output register is held.
// Reset: arst_n clears group phase, pad mark, error flag, count and all valid state.
`default_nettype none
module base64_decoder_crlf_skip #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        symbol_valid,
	output logic             symbol_ready,
	input  wire logic [7:0]  symbol,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       data_byte,
	output logic             end_of_message,
	output logic             bad_symbol_seen,
	output logic [15:0]      byte_count
);

	b64d_pkg::queue_status_t q_status;
	b64d_pkg::sym_class_t    push_data;
	b64d_pkg::sym_class_t    pop_data;
	logic                    push;
	logic                    pop;

	b64d_front u_front (
		.symbol_valid (symbol_valid),
		.symbol_ready (symbol_ready),
		.symbol       (symbol),
		.q_status     (q_status),
		.push         (push),
		.push_data    (push_data)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	b64d_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_status        (q_status),
		.q_data          (pop_data),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.data_byte       (data_byte),
		.end_of_message  (end_of_message),
		.bad_symbol_seen (bad_symbol_seen),
		.byte_count      (byte_count)
	);

	a_eom_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_message |-> data_byte == 8'd0)
		else $error("end-of-message word carries nonzero data");

	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.level <= b64d_pkg::Q_LVL_W'(b64d_pkg::Q_DEPTH))
		else $error("queue level beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty && (!result_valid || result_ready))
		else $error("queue popped while empty or output held");

endmodule
`default_nettype wire
